[hw/rtl/alsm_pkg.sv]
// ----------------------------------------------------------------------------
// alsm_pkg
// Shared constants, register codes and types of the angle link monitor.
// ----------------------------------------------------------------------------
package alsm_pkg;

    // Angle units are 1/2^ANGLE_FRAC_BITS degree; timers are TIMER_WIDTH bits.
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int TIMER_WIDTH     = 32;

    // Fixed field widths
    localparam int DT_W       = 20;
    localparam int RAW_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int OFFS_W     = 16;
    localparam int RATE_W     = 16;
    localparam int CFG_W      = 32;
    localparam int ANGLE_W    = 15;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_PERIOD    = 3'd5;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_RESET    = 16'sd256;
    localparam logic signed [OFFS_W-1:0] OFFSET_RESET  = 16'sd0;
    localparam logic [RATE_W-1:0]        RATE_RESET    = 16'd1280;
    localparam logic [CFG_W-1:0]         TIMEOUT_RESET = 32'd3000000;
    localparam logic [CFG_W-1:0]         PERIOD_RESET  = 32'd1000000;

    // Circle
    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam int TURN_W    = $clog2(FULL_TURN);
    localparam int SAMP_W    = $clog2(FULL_TURN + 1);
    localparam int HALF_W    = $clog2(HALF_TURN + 1);
    // smoothed + step reaches 1.5 turns before the wrap, plus a sign bit
    localparam int D_W       = TURN_W + 2;

    // Timers
    localparam int SUM_W = ((TIMER_WIDTH > DT_W) ? TIMER_WIDTH : DT_W) + 1;
    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [SUM_W-1:0] TIMER_MAX_EXT =
        {{(SUM_W-TIMER_WIDTH){1'b0}}, {TIMER_WIDTH{1'b1}}};

    // Gain and modulo reduction. A bias of whole turns makes the value
    // non-negative; FULL_TURN = 45 << (frac + 3), so the quotient is a shift
    // followed by a reciprocal multiply by 1/45 (exact for inputs < 74898).
    localparam int PROD_W      = SAMP_W + 1 + GAIN_W;
    localparam int SCALED_W    = PROD_W - 8;
    localparam int WRAP_TURNS  = 128 + (1 << (OFFS_W - 1)) / FULL_TURN + 2;
    localparam int WRAP_BIAS   = WRAP_TURNS * FULL_TURN;
    localparam int U_W         = $clog2(2 * WRAP_BIAS);
    localparam int V_W         = U_W + 2;
    localparam int Q_SHIFT     = ANGLE_FRAC_BITS + 3;
    localparam int QIN_W       = U_W - Q_SHIFT;
    localparam int RECIP45     = 46604;
    localparam int RECIP_SHIFT = 21;
    localparam int QM_W        = QIN_W + 16;
    localparam int Q_W         = QM_W - RECIP_SHIFT;

    // Alpha = floor(dt * rate * 256 / 1e6) = floor(4p / 15625), clamped to 1.0.
    localparam int RATE_PROD_W = DT_W + RATE_W;
    localparam int P_W         = 28;
    localparam int PM_W        = P_W + 31;
    localparam int ALPHA_SHIFT = 42;
    localparam int ALPHA_W     = PM_W - ALPHA_SHIFT;
    localparam logic [30:0] ALPHA_RECIP = 31'd1125899907;
    localparam logic [RATE_PROD_W-1:0] ALPHA_SAT_LIM = 36'd256003907;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // Smoothing step
    localparam int SMUL_W = HALF_W + ALPHA_W;
    localparam logic [SMUL_W:0] ROUND_HALF = (SMUL_W+1)'(32768);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [GAIN_W-1:0] angle_gain;
        logic signed [OFFS_W-1:0] angle_offset;
        logic                     smoothing_on;
        logic [RATE_W-1:0]        smoothing_rate;
        logic [CFG_W-1:0]         link_timeout_us;
        logic [CFG_W-1:0]         discovery_period_us;
    } cfg_t;

    typedef struct packed {
        logic [DT_W-1:0]   elapsed_us;
        logic              sample_ok;
        logic [SAMP_W-1:0] sample;
    } tick_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] processed_angle;
        logic [ANGLE_W-1:0] smoothed_angle;
        logic               angle_updated;
        logic               link_up;
        logic               link_changed;
        logic               discovery_pulse;
        logic [CNT_W-1:0]   accepted_count;
    } result_t;

endpackage

[hw/rtl/alsm_cfg.sv]
// ----------------------------------------------------------------------------
// alsm_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module alsm_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [alsm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [alsm_pkg::CFG_DATA_W-1:0]  wr_data,
    output alsm_pkg::cfg_t                   cfg
);
    import alsm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_gain          <= GAIN_RESET;
            cfg_reg.angle_offset        <= OFFSET_RESET;
            cfg_reg.smoothing_on        <= 1'b0;
            cfg_reg.smoothing_rate      <= RATE_RESET;
            cfg_reg.link_timeout_us     <= TIMEOUT_RESET;
            cfg_reg.discovery_period_us <= PERIOD_RESET;
        end else if (wr_en) begin
            case (wr_index)
                REG_ANGLE_GAIN:     cfg_reg.angle_gain          <= wr_data[GAIN_W-1:0];
                REG_ANGLE_OFFSET:   cfg_reg.angle_offset        <= wr_data[OFFS_W-1:0];
                REG_SMOOTHING_ON:   cfg_reg.smoothing_on        <= wr_data[0];
                REG_SMOOTHING_RATE: cfg_reg.smoothing_rate      <= wr_data[RATE_W-1:0];
                REG_LINK_TIMEOUT:   cfg_reg.link_timeout_us     <= wr_data[CFG_W-1:0];
                REG_DISC_PERIOD:    cfg_reg.discovery_period_us <= wr_data[CFG_W-1:0];
                default: ; // unknown index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/alsm_front.sv]
// ----------------------------------------------------------------------------
// alsm_front
// Input stage: takes an item, checks the sample range, holds it for the queue.
// ----------------------------------------------------------------------------
module alsm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [alsm_pkg::DT_W-1:0]     s_elapsed_us,
    input  logic                          s_sample_present,
    input  logic signed [alsm_pkg::RAW_W-1:0] s_sample_angle,
    output logic                          push_valid,
    input  logic                          push_ready,
    output alsm_pkg::tick_t               push_item
);
    import alsm_pkg::*;

    logic  hold_valid_reg;
    tick_t hold_reg;
    tick_t tick_next;
    logic  in_range;

    // valid sample: 0 .. full turn inclusive
    assign in_range = !s_sample_angle[RAW_W-1] &&
                      (s_sample_angle[RAW_W-2:0] <= (RAW_W-1)'(FULL_TURN));

    always_comb begin
        tick_next.elapsed_us = s_elapsed_us;
        tick_next.sample_ok  = s_sample_present && in_range;
        tick_next.sample     = s_sample_angle[SAMP_W-1:0];
    end

    assign s_ready = !hold_valid_reg || push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (push_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_reg <= tick_next;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_reg;

endmodule

[hw/rtl/alsm_queue.sv]
// ----------------------------------------------------------------------------
// alsm_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module alsm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  alsm_pkg::tick_t  wr_item,
    output logic             rd_valid,
    input  logic             rd_ready,
    output alsm_pkg::tick_t  rd_item
);
    import alsm_pkg::*;

    tick_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_wr, do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_rd) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[hw/rtl/alsm_back.sv]
// ----------------------------------------------------------------------------
// alsm_back
// Execution sequencer: timers, link state, scaling with modulo, smoothing.
// ----------------------------------------------------------------------------
module alsm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  alsm_pkg::cfg_t    cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  alsm_pkg::tick_t   q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output alsm_pkg::result_t m_result
);
    import alsm_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_WRAP   = 3'd2;
    localparam logic [2:0] ST_SMUL   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    // architectural state
    logic [TURN_W-1:0]      proc_reg, smooth_reg;
    logic                   link_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [TIMER_WIDTH-1:0] sil_reg, disc_reg;

    // per-item working registers
    logic                          ok_reg, updated_reg, changed_reg, pulse_reg;
    logic signed [PROD_W-1:0]      gain_prod_reg;
    logic [RATE_PROD_W-1:0]        rate_prod_reg;
    logic [U_W-1:0]                u_reg;
    logic [QM_W-1:0]               qm_reg;
    logic [PM_W-1:0]               pm_reg;
    logic                          alpha_sat_reg;
    logic [ALPHA_W-1:0]            alpha_reg;
    logic [SMUL_W-1:0]             mul_reg;
    logic                          neg_reg;

    logic    m_valid_reg;
    result_t m_result_reg;

    // idle step: timers and link
    logic [SUM_W-1:0]       dt_ext, disc_sum, sil_sum;
    logic [TIMER_WIDTH-1:0] disc_sat, sil_sat;
    logic                   pulse_now, drop_now;

    // reduce / wrap
    logic signed [SCALED_W-1:0] scaled;
    logic signed [V_W-1:0]      v_sum;
    logic [U_W-1:0]             u_next;
    logic [QM_W-1:0]            qm_next;
    logic [PM_W-1:0]            pm_next;
    logic [Q_W-1:0]             quot;
    logic [U_W-1:0]             rem_full;
    logic [ALPHA_W-1:0]         alpha_next;

    // smoothing
    logic signed [D_W-1:0] diff, diff_fold, sm_sum;
    logic [HALF_W-1:0]     diff_abs, mag;
    logic [SMUL_W:0]       rounded;
    logic [TURN_W-1:0]     smooth_next;
    logic                  out_free;

    always_comb begin
        dt_ext    = SUM_W'(q_item.elapsed_us);
        disc_sum  = SUM_W'(disc_reg) + dt_ext;
        disc_sat  = (disc_sum > TIMER_MAX_EXT) ? '1 : disc_sum[TIMER_WIDTH-1:0];
        pulse_now = CMP_W'(disc_sat) >= CMP_W'(cfg.discovery_period_us);
        sil_sum   = SUM_W'(sil_reg) + dt_ext;
        sil_sat   = (sil_sum > TIMER_MAX_EXT) ? '1 : sil_sum[TIMER_WIDTH-1:0];
        drop_now  = link_reg && (CMP_W'(sil_sat) > CMP_W'(cfg.link_timeout_us));
    end

    always_comb begin
        scaled  = gain_prod_reg[PROD_W-1:8];
        v_sum   = V_W'(scaled) + V_W'(cfg.angle_offset) + V_W'(WRAP_BIAS);
        u_next  = v_sum[U_W-1:0];
        qm_next = QM_W'(u_next[U_W-1:Q_SHIFT]) * QM_W'(RECIP45);
        pm_next = PM_W'(rate_prod_reg[P_W-1:0]) * PM_W'(ALPHA_RECIP);
    end

    always_comb begin
        quot       = qm_reg[QM_W-1:RECIP_SHIFT];
        rem_full   = u_reg - U_W'(quot * FULL_TURN);
        alpha_next = alpha_sat_reg ? ALPHA_ONE : pm_reg[ALPHA_SHIFT +: ALPHA_W];
    end

    // shortest way round: fold the difference into [-half, half]
    always_comb begin
        diff = $signed({1'b0, proc_reg}) - $signed({1'b0, smooth_reg});
        if (diff > D_W'(HALF_TURN)) begin
            diff_fold = diff - D_W'(FULL_TURN);
        end else if (diff < -D_W'(HALF_TURN)) begin
            diff_fold = diff + D_W'(FULL_TURN);
        end else begin
            diff_fold = diff;
        end
        diff_abs = diff_fold[D_W-1] ? HALF_W'(-diff_fold) : HALF_W'(diff_fold);
    end

    // round half away from zero, then wrap once
    always_comb begin
        rounded = (SMUL_W+1)'(mul_reg) + ROUND_HALF;
        mag     = rounded[16 +: HALF_W];
        sm_sum  = neg_reg ? ($signed({1'b0, smooth_reg}) - $signed(D_W'(mag)))
                          : ($signed({1'b0, smooth_reg}) + $signed(D_W'(mag)));
        if (sm_sum < 0) begin
            sm_sum = sm_sum + D_W'(FULL_TURN);
        end else if (sm_sum >= D_W'(FULL_TURN)) begin
            sm_sum = sm_sum - D_W'(FULL_TURN);
        end
        smooth_next = cfg.smoothing_on ? sm_sum[TURN_W-1:0] : proc_reg;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_SMUL;
            ST_SMUL:   state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            proc_reg    <= '0;
            smooth_reg  <= '0;
            link_reg    <= 1'b0;
            count_reg   <= '0;
            sil_reg     <= '0;
            disc_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && q_valid) begin
                disc_reg <= pulse_now ? '0 : disc_sat;
                if (q_item.sample_ok) begin
                    count_reg <= count_reg + 1'b1;
                    sil_reg   <= '0;
                    link_reg  <= 1'b1;
                end else begin
                    sil_reg <= sil_sat;
                    if (drop_now) link_reg <= 1'b0;
                end
            end
            if (state_reg == ST_WRAP && ok_reg) begin
                proc_reg <= rem_full[TURN_W-1:0];
            end
            if (state_reg == ST_FINISH && out_free) begin
                smooth_reg  <= smooth_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ok_reg        <= q_item.sample_ok;
                updated_reg   <= q_item.sample_ok;
                changed_reg   <= q_item.sample_ok ? !link_reg : drop_now;
                pulse_reg     <= pulse_now;
                gain_prod_reg <= $signed(PROD_W'(q_item.sample)) *
                                 PROD_W'(cfg.angle_gain);
                rate_prod_reg <= RATE_PROD_W'(q_item.elapsed_us) *
                                 RATE_PROD_W'(cfg.smoothing_rate);
            end
            ST_REDUCE: begin
                u_reg         <= u_next;
                qm_reg        <= qm_next;
                pm_reg        <= pm_next;
                alpha_sat_reg <= rate_prod_reg >= ALPHA_SAT_LIM;
            end
            ST_WRAP: begin
                alpha_reg <= alpha_next;
            end
            ST_SMUL: begin
                neg_reg <= diff_fold[D_W-1];
                mul_reg <= SMUL_W'(diff_abs) * SMUL_W'(alpha_reg);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_result_reg.processed_angle <= ANGLE_W'(proc_reg);
                    m_result_reg.smoothed_angle  <= ANGLE_W'(smooth_next);
                    m_result_reg.angle_updated   <= updated_reg;
                    m_result_reg.link_up         <= link_reg;
                    m_result_reg.link_changed    <= changed_reg;
                    m_result_reg.discovery_pulse <= pulse_reg;
                    m_result_reg.accepted_count  <= count_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

[hw/rtl/angle_scale_smooth_link_monitor.sv]
// ----------------------------------------------------------------------------
// angle_scale_smooth_link_monitor
// Per-tick angle link monitor: range check, gain/offset with true modulo,
// silence timeout, discovery pulse and wrap-aware exponential smoothing.
// ----------------------------------------------------------------------------
//
//  channel   ports                         moves
//  --------  ----------------------------  -----------------------------------
//  s_        s_valid / s_ready             one tick item: dt, sample, angle
//  m_        m_valid / m_ready             one result item per tick
//  cfg_      cfg_valid / cfg_ready         register write: index, data
//
//  Each item passes the back sequencer steps in order (timers, reduce,
//  wrap, smoothing multiply, finish; finish holds while m_ is stalled).
//  It takes no new item before the last is done, which sets the rate.
//  The front stage and a 2-entry queue keep taking items while the back
//  works or m_ waits. cfg_ready is always high. Reset is synchronous, active
//  low; no clearing pass.
//
module angle_scale_smooth_link_monitor (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tick input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [alsm_pkg::DT_W-1:0]            s_elapsed_us,
    input  logic                                 s_sample_present,
    input  logic signed [alsm_pkg::RAW_W-1:0]    s_sample_angle,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [alsm_pkg::ANGLE_W-1:0]         m_processed_angle,
    output logic [alsm_pkg::ANGLE_W-1:0]         m_smoothed_angle,
    output logic                                 m_angle_updated,
    output logic                                 m_link_up,
    output logic                                 m_link_changed,
    output logic                                 m_discovery_pulse,
    output logic [alsm_pkg::CNT_W-1:0]           m_accepted_count,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [alsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [alsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import alsm_pkg::*;

    cfg_t    cfg;
    tick_t   push_item, pop_item;
    logic    push_valid, push_ready;
    logic    pop_valid, pop_ready;
    result_t result;

    // the register file takes every write, so the port never stalls
    assign cfg_ready = 1'b1;

    alsm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // front: accept and classify (sample in 0..360 degrees)
    alsm_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_us     (s_elapsed_us),
        .s_sample_present (s_sample_present),
        .s_sample_angle   (s_sample_angle),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    // decoupling queue
    alsm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    // back: one item at a time, result held in an output register
    alsm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_item   (pop_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_processed_angle = result.processed_angle;
    assign m_smoothed_angle  = result.smoothed_angle;
    assign m_angle_updated   = result.angle_updated;
    assign m_link_up         = result.link_up;
    assign m_link_changed    = result.link_changed;
    assign m_discovery_pulse = result.discovery_pulse;
    assign m_accepted_count  = result.accepted_count;

endmodule
